[design/spim_pkg.sv]
package spim_pkg;

	// Fixed transfer length
	localparam int BYTE_BITS = 8;

	// Request types
	localparam logic [1:0] REQ_TICK  = 2'd0;
	localparam logic [1:0] REQ_WRITE = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;

	// Register selects
	localparam logic [1:0] SEL_PINS   = 2'd0;
	localparam logic [1:0] SEL_TX     = 2'd1;
	localparam logic [1:0] SEL_RX     = 2'd2;
	localparam logic [1:0] SEL_STATUS = 2'd3;

	// Configuration register indexes
	localparam logic CFG_OUTPUT_MODE   = 1'b0;
	localparam logic CFG_CLOCK_DIVISOR = 1'b1;

	// Direct pin register bit positions
	localparam int PIN_SCLK   = 0;
	localparam int PIN_SELECT = 1;
	localparam int PIN_MOSI   = 3;

	localparam logic [3:0] PINS_RESET = 4'b1111;
	localparam logic [3:0] PINS_READ_MASK = 4'b1011;

	// Command classes decided by the front end
	typedef enum logic [2:0] {
		OP_NOP,
		OP_TICK,
		OP_WR_PINS,
		OP_WR_TX,
		OP_READ
	} op_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic [1:0] reg_sel;
		logic [7:0] write_data;
		logic       miso_pin;
	} in_item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       sclk_pin;
		logic       mosi_pin;
		logic       select_pin;
	} out_item_t;

	typedef struct packed {
		op_t        op;
		logic [1:0] reg_sel;
		logic [7:0] write_data;
		logic       miso_pin;
	} cmd_t;

	typedef struct packed {
		logic        output_mode;
		logic [15:0] clock_divisor;
	} cfg_t;

endpackage

[design/spim_fifo.sv]
module spim_fifo #(
	parameter type T = logic,
	parameter int DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  T     wdata,
	output logic full,
	input  logic pop,
	output T     rdata,
	output logic empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	T              mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[design/spim_front.sv]
module spim_front #(
	parameter int CMD_DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  spim_pkg::in_item_t request,
	output logic              full,
	input  logic              cmd_pop,
	output spim_pkg::cmd_t    cmd,
	output logic              cmd_empty
);

	spim_pkg::cmd_t decoded;

	// Classify the transaction
	always_comb begin
		decoded.reg_sel    = request.reg_sel;
		decoded.write_data = request.write_data;
		decoded.miso_pin   = request.miso_pin;
		case (request.req_type)
			spim_pkg::REQ_TICK: decoded.op = spim_pkg::OP_TICK;
			spim_pkg::REQ_WRITE: begin
				case (request.reg_sel)
					spim_pkg::SEL_PINS: decoded.op = spim_pkg::OP_WR_PINS;
					spim_pkg::SEL_TX:   decoded.op = spim_pkg::OP_WR_TX;
					default:            decoded.op = spim_pkg::OP_NOP;
				endcase
			end
			spim_pkg::REQ_READ: decoded.op = spim_pkg::OP_READ;
			default:            decoded.op = spim_pkg::OP_NOP;
		endcase
	end

	// Command queue toward the engine
	spim_fifo #(
		.T     (spim_pkg::cmd_t),
		.DEPTH (CMD_DEPTH)
	) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (decoded),
		.full   (full),
		.pop    (cmd_pop),
		.rdata  (cmd),
		.empty  (cmd_empty)
	);

endmodule

[design/spim_back.sv]
module spim_back #(
	parameter int RES_DEPTH = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  spim_pkg::cfg_t      cfg,
	input  spim_pkg::cmd_t      cmd,
	input  logic                cmd_empty,
	output logic                cmd_pop,
	output spim_pkg::out_item_t result,
	output logic                empty,
	input  logic                pop
);

	logic [3:0]  pins_q,  pins_d;
	logic [7:0]  tx_q,    tx_d;
	logic [7:0]  rx_q,    rx_d;
	logic [7:0]  hold_q,  hold_d;
	logic [3:0]  bits_q,  bits_d;
	logic [15:0] cnt_q,   cnt_d;
	logic        sclk_q,  sclk_d;
	logic        busy_q,  busy_d;

	logic        res_full;
	logic        step;
	logic [15:0] div;
	logic [15:0] cnt_inc;
	logic [7:0]  rx_shifted;
	logic [3:0]  bits_dec;
	spim_pkg::out_item_t res;

	assign step    = !cmd_empty && !res_full;
	assign cmd_pop = step;

	assign div        = (cfg.clock_divisor == '0) ? 16'd1 : cfg.clock_divisor;
	assign cnt_inc    = cnt_q + 16'd1;
	assign rx_shifted = {rx_q[6:0], cmd.miso_pin};
	assign bits_dec   = bits_q - 4'd1;

	// Engine next state
	always_comb begin
		pins_d = pins_q;
		tx_d   = tx_q;
		rx_d   = rx_q;
		hold_d = hold_q;
		bits_d = bits_q;
		cnt_d  = cnt_q;
		sclk_d = sclk_q;
		busy_d = busy_q;
		case (cmd.op)
			spim_pkg::OP_TICK: begin
				if (busy_q) begin
					if (cnt_inc < div) begin
						cnt_d = cnt_inc;
					end else begin
						cnt_d = '0;
						if (sclk_q) begin
							// falling edge: next bit out (first bit already shown)
							sclk_d = 1'b0;
							if (bits_q < 4'(spim_pkg::BYTE_BITS)) begin
								tx_d = {tx_q[6:0], 1'b0};
							end
						end else begin
							// rising edge: sample MISO
							sclk_d = 1'b1;
							rx_d   = rx_shifted;
							bits_d = bits_dec;
							if (bits_dec == '0) begin
								hold_d = rx_shifted;
								busy_d = 1'b0;
							end
						end
					end
				end
			end
			spim_pkg::OP_WR_PINS: pins_d = cmd.write_data[3:0];
			spim_pkg::OP_WR_TX: begin
				if (!busy_q) begin
					tx_d   = cmd.write_data;
					rx_d   = '0;
					bits_d = 4'(spim_pkg::BYTE_BITS);
					cnt_d  = '0;
					sclk_d = 1'b1;
					busy_d = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// Result: read data from current state, pins after the update
	always_comb begin
		res.read_data = '0;
		if (cmd.op == spim_pkg::OP_READ) begin
			case (cmd.reg_sel)
				spim_pkg::SEL_PINS:
					res.read_data = {4'b0000, (pins_q & spim_pkg::PINS_READ_MASK)} |
						{5'b00000, cmd.miso_pin, 2'b00};
				spim_pkg::SEL_TX:     res.read_data = tx_q;
				spim_pkg::SEL_RX:     res.read_data = hold_q;
				spim_pkg::SEL_STATUS: res.read_data = {7'b0000000, !busy_q};
				default:              res.read_data = '0;
			endcase
		end
		if (cfg.output_mode) begin
			res.sclk_pin = sclk_d;
			res.mosi_pin = tx_d[7];
		end else begin
			res.sclk_pin = pins_d[spim_pkg::PIN_SCLK];
			res.mosi_pin = pins_d[spim_pkg::PIN_MOSI];
		end
		res.select_pin = pins_d[spim_pkg::PIN_SELECT];
	end

	// Engine state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pins_q <= spim_pkg::PINS_RESET;
			tx_q   <= '0;
			rx_q   <= '0;
			hold_q <= '0;
			bits_q <= '0;
			cnt_q  <= '0;
			sclk_q <= 1'b1;
			busy_q <= 1'b0;
		end else if (step) begin
			pins_q <= pins_d;
			tx_q   <= tx_d;
			rx_q   <= rx_d;
			hold_q <= hold_d;
			bits_q <= bits_d;
			cnt_q  <= cnt_d;
			sclk_q <= sclk_d;
			busy_q <= busy_d;
		end
	end

	// Result queue
	spim_fifo #(
		.T     (spim_pkg::out_item_t),
		.DEPTH (RES_DEPTH)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (step),
		.wdata  (res),
		.full   (res_full),
		.pop    (pop),
		.rdata  (result),
		.empty  (empty)
	);

endmodule

[design/spi_master_with_direct_pin_mode_unit.sv]
// SPI master (mode 3, MSB first) with a direct pin register, driven one
// transaction at a time. Each input transaction is a system tick, a register
// write or a register read; every one yields exactly one result carrying the
// read data and the sclk, mosi and select levels after that transaction.
// Input: push/full, accepted when push is high and full is low.
// Output: empty/pop, the oldest result sits on result while empty is low.
// Config: cfg_we/cfg_idx/cfg_wdata, index 0 output mode, 1 clock divisor;
// write only while the unit is idle.
// A result reaches the result ports after its transaction has been taken
// and has passed the command queue and then the engine step into the result
// queue; the step waits while the result queue is full.
// Throughput: one transaction per cycle while the result queue has room, set
// by the engine which updates its whole state in one step.
// When pop is held low the result queue fills, the engine stops, and the
// command queue absorbs up to CMD_DEPTH more transactions before full rises.
// Reset: queues empty, direct pins all high, engine idle with clock high,
// output mode 0, divisor 1.
module spi_master_with_direct_pin_mode_unit #(
	parameter int CMD_DEPTH = 4,
	parameter int RES_DEPTH = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  spim_pkg::in_item_t  request,
	output logic                empty,
	input  logic                pop,
	output spim_pkg::out_item_t result,
	input  logic                cfg_we,
	input  logic                cfg_idx,
	input  logic [15:0]         cfg_wdata
);

	spim_pkg::cfg_t cfg_q;
	spim_pkg::cmd_t cmd;
	logic           cmd_empty;
	logic           cmd_pop;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.output_mode   <= 1'b0;
			cfg_q.clock_divisor <= 16'd1;
		end else if (cfg_we) begin
			case (cfg_idx)
				spim_pkg::CFG_OUTPUT_MODE:   cfg_q.output_mode <= cfg_wdata[0];
				spim_pkg::CFG_CLOCK_DIVISOR: cfg_q.clock_divisor <= cfg_wdata;
				default: ;
			endcase
		end
	end

	spim_front #(
		.CMD_DEPTH (CMD_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.request   (request),
		.full      (full),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd),
		.cmd_empty (cmd_empty)
	);

	spim_back #(
		.RES_DEPTH (RES_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd       (cmd),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.result    (result),
		.empty     (empty),
		.pop       (pop)
	);

endmodule
